// ===== rtl/cgc_pkg.sv =====
// ----------------------------------------------------------------------------
// cgc_pkg
// Shared codes, field widths and the divider request/response types of the
// capacity-limited greedy colouring block.
// ----------------------------------------------------------------------------
package cgc_pkg;

  // Item field widths
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned END_W   = 7;
  localparam int unsigned EDGE_W  = 2 * END_W;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned OUT_W   = 8;

  // Size limit divider: numerator holds vertex_count + team_target + 1
  localparam int unsigned DIV_NUM_W = 10;
  localparam int unsigned DIV_DEN_W = CFG_W;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Register indexes
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_TEAM_TARGET  = 1'b1;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/capacity_limited_greedy_coloring_top.sv =====
// ----------------------------------------------------------------------------
// capacity_limited_greedy_coloring_top
// Edge list with greedy, size-limited colouring run under a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one item: kind_i selects
//   add edge (edge_from_i, edge_to_i), run colouring or clear edge list.
//   An add or a clear gives no result; an add into a full list is dropped
//   and sets the overflow flag, which a clear resets.
//   A run gives one result on the output channel (out_valid_o/out_ready_i):
//   class_count_o, fits_o and edge_overflow_o.
//   A run scans N vertices over R rounds (up to N + 1), walking all E stored
//   edges through the single compare pipeline for each candidate vertex.
//   It first runs the size limit divider (ten bits, one a cycle, then a
//   done strobe), then a clearing pass over N entries resets the
//   placement memory; at the end the output register is loaded. in_ready_o
//   is low while a run is in progress. The result sits in an output
//   register: the next item is taken while it waits; a run that finishes
//   while the register is still full holds until out_ready_i. Reset empties
//   the edge list, clears the flag, sets vertex_count to 0 and team_target
//   to 1. Registers are written over the APB port; the user writes them
//   only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module capacity_limited_greedy_coloring_top #(
  parameter int unsigned MAX_VERTICES   = 128,
  parameter int unsigned MAX_EDGE_COUNT = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // Input items
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [cgc_pkg::KIND_W-1:0]        kind_i,
  input  logic [cgc_pkg::END_W-1:0]         edge_from_i,
  input  logic [cgc_pkg::END_W-1:0]         edge_to_i,
  // Result items
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cgc_pkg::OUT_W-1:0]         class_count_o,
  output logic                              fits_o,
  output logic                              edge_overflow_o
);

  localparam int unsigned VCW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned VAW  = $clog2(MAX_VERTICES);
  localparam int unsigned MW   = 1 + VCW;
  localparam int unsigned ECW  = $clog2(MAX_EDGE_COUNT + 1);
  localparam int unsigned EAW  = (MAX_EDGE_COUNT > 1) ? $clog2(MAX_EDGE_COUNT) : 1;
  localparam int unsigned CMPW = (VCW > cgc_pkg::CFG_W) ? VCW : cgc_pkg::CFG_W;
  localparam int unsigned NW   = cgc_pkg::DIV_NUM_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIV    = 4'd1;
  localparam logic [3:0] S_CLR    = 4'd2;
  localparam logic [3:0] S_ROUND  = 4'd3;
  localparam logic [3:0] S_VTX    = 4'd4;
  localparam logic [3:0] S_VCHK   = 4'd5;
  localparam logic [3:0] S_SCAN   = 4'd6;
  localparam logic [3:0] S_DECIDE = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  // Configuration registers
  logic [cgc_pkg::CFG_W-1:0] vcount_q, team_q;
  logic                      cfg_we;

  // Edge list control
  logic [ECW-1:0] edge_cnt_q, edge_cnt_d;
  logic           ovf_q, ovf_d;
  logic           in_acc, list_full, edge_we;

  // Sequencer
  logic [3:0]     state_q, state_d;
  logic [VCW-1:0] n_q, n_d;
  logic [NW-1:0]  limit_q, limit_d;
  logic [VCW-1:0] clr_q, clr_d;
  logic [VCW-1:0] v_q, v_d;
  logic [VCW-1:0] fill_q, fill_d;
  logic [VCW-1:0] class_q, class_d;
  logic           round_hit_q, round_hit_d;
  logic [ECW-1:0] e_q, e_d;
  logic           conflict_q, conflict_d;
  logic           issuing;

  // Edge compare pipeline
  logic                        s1_valid_q, s1_valid_d;
  logic                        s2_valid_q, s2_valid_d;
  logic                        s2_inr_q, s2_inr_d;
  logic [cgc_pkg::EDGE_W-1:0]  edge_rdata;
  logic [cgc_pkg::END_W-1:0]   end_a, end_b, other;
  logic                        hit_a, hit_b, mark_hit;

  // Mark memory ports
  logic           mark_we;
  logic [VAW-1:0] mark_waddr;
  logic [MW-1:0]  mark_wdata;
  logic [MW-1:0]  mark_rdata_a, mark_rdata_b;

  // Divider
  cgc_pkg::div_req_t div_req;
  cgc_pkg::div_rsp_t div_rsp;

  // Output register
  logic                      out_valid_q, out_valid_d;
  logic [cgc_pkg::OUT_W-1:0] out_count_q;
  logic                      out_fits_q, out_ovf_q;
  logic                      out_load;
  logic                      fits_now;

  // --------------------------------------------------------------------------
  // APB port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      cgc_pkg::REG_VERTEX_COUNT: prdata = 32'(vcount_q);
      cgc_pkg::REG_TEAM_TARGET:  prdata = 32'(team_q);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
      team_q   <= 8'd1;
    end else if (cfg_we) begin
      if (paddr[2] == cgc_pkg::REG_TEAM_TARGET) begin
        team_q <= pwdata[cgc_pkg::CFG_W-1:0];
      end else begin
        vcount_q <= pwdata[cgc_pkg::CFG_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input handshake and edge list bookkeeping
  // --------------------------------------------------------------------------
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign list_full  = (32'(edge_cnt_q) >= MAX_EDGE_COUNT);
  assign edge_we    = in_acc && (kind_i == cgc_pkg::KIND_ADD) && !list_full;

  always_comb begin
    edge_cnt_d = edge_cnt_q;
    ovf_d      = ovf_q;
    if (in_acc) begin
      unique case (kind_i)
        cgc_pkg::KIND_ADD: begin
          if (list_full) begin
            ovf_d = 1'b1;
          end else begin
            edge_cnt_d = edge_cnt_q + 1'b1;
          end
        end
        cgc_pkg::KIND_CLEAR: begin
          edge_cnt_d = '0;
          ovf_d      = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  cgc_edge_ram #(
    .DEPTH (MAX_EDGE_COUNT),
    .AW    (EAW)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_cnt_q[EAW-1:0]),
    .wdata_i ({edge_from_i, edge_to_i}),
    .raddr_i (e_q[EAW-1:0]),
    .rdata_o (edge_rdata)
  );

  // --------------------------------------------------------------------------
  // Size limit divider
  // --------------------------------------------------------------------------
  assign div_req.start = in_acc && (kind_i == cgc_pkg::KIND_RUN);
  assign div_req.num   = NW'(vcount_q) + NW'(team_q) + NW'(1);
  assign div_req.den   = (team_q == '0) ? cgc_pkg::DIV_DEN_W'(1) : team_q;

  cgc_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Edge compare pipeline: stage 1 matches the candidate, stage 2 checks
  // whether the other endpoint sits in the current class
  // --------------------------------------------------------------------------
  assign issuing = (e_q != edge_cnt_q);
  assign end_a   = edge_rdata[cgc_pkg::EDGE_W-1:cgc_pkg::END_W];
  assign end_b   = edge_rdata[cgc_pkg::END_W-1:0];
  assign hit_a   = (32'(end_a) == 32'(v_q));
  assign hit_b   = (32'(end_b) == 32'(v_q));
  assign other   = hit_a ? end_b : end_a;

  assign s1_valid_d = (state_q == S_SCAN) && issuing;
  assign s2_valid_d = s1_valid_q && (hit_a || hit_b);
  assign s2_inr_d   = (32'(other) < 32'(n_q));
  assign mark_hit   = s2_valid_q && s2_inr_q && mark_rdata_b[MW-1] &&
                      (mark_rdata_b[VCW-1:0] == class_q);

  // --------------------------------------------------------------------------
  // Placement memory
  // --------------------------------------------------------------------------
  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = clr_q[VAW-1:0];
    mark_wdata = '0;
    if (state_q == S_CLR) begin
      mark_we = 1'b1;
    end else if ((state_q == S_DECIDE) && !conflict_q) begin
      mark_we    = 1'b1;
      mark_waddr = v_q[VAW-1:0];
      mark_wdata = {1'b1, class_q};
    end
  end

  cgc_mark_ram #(
    .DEPTH (MAX_VERTICES),
    .AW    (VAW),
    .WIDTH (MW)
  ) u_mark_ram (
    .clk_i     (clk_i),
    .we_i      (mark_we),
    .waddr_i   (mark_waddr),
    .wdata_i   (mark_wdata),
    .raddr_a_i (v_q[VAW-1:0]),
    .rdata_a_o (mark_rdata_a),
    .raddr_b_i (VAW'(other)),
    .rdata_b_o (mark_rdata_b)
  );

  // --------------------------------------------------------------------------
  // Run sequencer
  // --------------------------------------------------------------------------
  assign fits_now = (vcount_q >= team_q) && (CMPW'(class_q) <= CMPW'(team_q));
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    limit_d     = limit_q;
    clr_d       = clr_q;
    v_d         = v_q;
    fill_d      = fill_q;
    class_d     = class_q;
    round_hit_d = round_hit_q;
    e_d         = e_q;
    conflict_d  = conflict_q;
    unique case (state_q)
      S_IDLE: begin
        if (div_req.start) begin
          n_d     = (32'(vcount_q) > MAX_VERTICES) ? VCW'(MAX_VERTICES) : VCW'(vcount_q);
          class_d = '0;
          clr_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          limit_d = div_rsp.quot;
          state_d = (n_q == '0) ? S_ROUND : S_CLR;
        end
      end
      S_CLR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == n_q - 1'b1) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        v_d         = '0;
        fill_d      = '0;
        round_hit_d = 1'b0;
        state_d     = S_VTX;
      end
      S_VTX: begin
        if (v_q == n_q) begin
          if (round_hit_q) begin
            class_d = class_q + 1'b1;
            state_d = S_ROUND;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          state_d = S_VCHK;
        end
      end
      S_VCHK: begin
        // Skip vertices already placed, and all once the class is full
        if (mark_rdata_a[MW-1] || (32'(fill_q) >= 32'(limit_q))) begin
          v_d     = v_q + 1'b1;
          state_d = S_VTX;
        end else begin
          e_d        = '0;
          conflict_d = 1'b0;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issuing) begin
          e_d = e_q + 1'b1;
        end
        if (mark_hit) begin
          conflict_d = 1'b1;
        end
        if (!issuing && !s1_valid_q && !s2_valid_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!conflict_q) begin
          fill_d      = fill_q + 1'b1;
          round_hit_d = 1'b1;
        end
        v_d     = v_q + 1'b1;
        state_d = S_VTX;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: load wins over a take in the same cycle
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      edge_cnt_q  <= '0;
      ovf_q       <= 1'b0;
      limit_q     <= '0;
      fill_q      <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      edge_cnt_q  <= edge_cnt_d;
      ovf_q       <= ovf_d;
      limit_q     <= limit_d;
      fill_q      <= fill_d;
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    clr_q       <= clr_d;
    v_q         <= v_d;
    class_q     <= class_d;
    round_hit_q <= round_hit_d;
    e_q         <= e_d;
    conflict_q  <= conflict_d;
    s2_inr_q    <= s2_inr_d;
    if (out_load) begin
      out_count_q <= cgc_pkg::OUT_W'(class_q);
      out_fits_q  <= fits_now;
      out_ovf_q   <= ovf_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign class_count_o   = out_count_q;
  assign fits_o          = out_fits_q;
  assign edge_overflow_o = out_ovf_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_edge_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(edge_cnt_q) <= MAX_EDGE_COUNT)
    else $error("edge count beyond store depth");

  a_s2_follows_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> $past(s1_valid_q))
    else $error("compare stage 2 without stage 1");

  a_decide_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE) |-> (!s1_valid_q && !s2_valid_q && !issuing))
    else $error("decision taken before edge walk drained");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_VTX) || (state_q == S_VCHK) || (state_q == S_SCAN) ||
     (state_q == S_DECIDE)) |-> (32'(fill_q) <= 32'(limit_q)))
    else $error("class fill beyond size limit");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_req.start) |=> !in_ready_o)
    else $error("item taken while a run is in progress");

endmodule

// ===== rtl/cgc_divider.sv =====
// ----------------------------------------------------------------------------
// cgc_divider
// Restoring divider, one quotient bit per cycle, for the class size limit.
// ----------------------------------------------------------------------------
module cgc_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cgc_pkg::div_req_t req_i,
  output cgc_pkg::div_rsp_t rsp_o
);

  localparam int unsigned NW = cgc_pkg::DIV_NUM_W;
  localparam int unsigned DW = cgc_pkg::DIV_DEN_W;
  localparam int unsigned CNTW = $clog2(NW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [NW-1:0]   num_q, num_d;
  logic [DW-1:0]   den_q, den_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW:0]     trial;
  logic            ge;

  // Shift in the next numerator bit and subtract where it fits
  assign trial = {rem_q, num_q[NW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? DW'(trial - {1'b0, den_q}) : DW'(trial);
      num_d = {num_q[NW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNTW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule

// ===== rtl/cgc_edge_ram.sv =====
// ----------------------------------------------------------------------------
// cgc_edge_ram
// Edge list memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cgc_edge_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [cgc_pkg::EDGE_W-1:0]  wdata_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [cgc_pkg::EDGE_W-1:0]  rdata_o
);

  logic [cgc_pkg::EDGE_W-1:0] mem [DEPTH];

  // Write, and a registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/cgc_mark_ram.sv =====
// ----------------------------------------------------------------------------
// cgc_mark_ram
// Per-vertex placement memory: placed flag and class, two registered reads.
// ----------------------------------------------------------------------------
module cgc_mark_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7,
  parameter int unsigned WIDTH = 9
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read two
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule
